>>> hdl/cba_pkg.sv
// shared types and constants for the contiguous block allocator
// no dependencies; imported by every module of the block
package cba_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int LEN_W      = $clog2(NUM_BLOCKS + 1);
  localparam int REQ_W      = 1;
  localparam int CNT_IN_W   = 5;
  localparam int BIDX_W     = 4;
  localparam int RC_W       = 2;
  localparam int START_W    = 4;
  localparam int CMP_W      = (LEN_W > CNT_IN_W) ? LEN_W : CNT_IN_W;

  typedef enum logic [2:0] {
    TAG_FREE   = 3'd0,
    TAG_SINGLE = 3'd1,
    TAG_FIRST  = 3'd2,
    TAG_MIDDLE = 3'd3,
    TAG_LAST   = 3'd4
  } tag_t;

  localparam logic [RC_W-1:0] RC_OK      = 2'd0;
  localparam logic [RC_W-1:0] RC_NOSPACE = 2'd1;
  localparam logic [RC_W-1:0] RC_BADFREE = 2'd2;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 1'b0;

  // write port of the tag store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    tag_t             data;
  } tag_wr_t;

  // command to the run counter
  typedef struct packed {
    logic clr;
    logic step;
  } run_cmd_t;

  // status from the run counter
  typedef struct packed {
    logic len_zero;
    logic hit;
  } run_sts_t;

endpackage

>>> hdl/contiguous_block_allocator_top.sv
// first-fit contiguous block allocator, one beat in, one beat out per request
// steps to out_valid: allocate scans the tags for the first long enough free run (or to the
//   heap end), then tags that run block by block; a zero or oversize count goes straight to the
//   result; free checks the head tag, then clears the run block by block (a bad index goes straight on)
// throughput: one request at a time, in_ready rises with out_valid; a stalled result holds it
// reset: synchronous active-low rst_n marks every block free and empties the output
module contiguous_block_allocator_top
  import cba_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [CNT_IN_W-1:0] in_alloc_count,
  input  logic [BIDX_W-1:0]   in_block_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RC_W-1:0]     out_result_code,
  output logic [START_W-1:0]  out_start_index
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_FREE_HEAD,
    S_FREE_WALK,
    S_DONE
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [IDX_W-1:0]   start_r, start_nxt;
  logic [LEN_W-1:0]   count_r, count_nxt;
  logic [RC_W-1:0]    rc_r, rc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [RC_W-1:0]    out_rc_r, out_rc_nxt;
  logic [START_W-1:0] out_start_r, out_start_nxt;

  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] bidx_ext;
  tag_t             rd_tag;
  tag_wr_t          wr;
  run_cmd_t         run_cmd;
  run_sts_t         run_sts;
  logic             in_beat;
  logic             out_free;

  cba_tag_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (ptr_r),
    .rd_data (rd_tag)
  );

  cba_run_unit u_run (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (run_cmd),
    .count (count_r),
    .sts   (run_sts)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign in_beat         = in_valid & in_ready;
  assign out_free        = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_result_code = out_rc_r;
  assign out_start_index = out_start_r;
  assign cnt_ext         = CMP_W'(in_alloc_count);
  assign bidx_ext        = CMP_W'(in_block_index);

  // sequencer: scan, tag, free walk
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    start_nxt     = start_r;
    count_nxt     = count_r;
    rc_nxt        = rc_r;
    out_valid_nxt = out_valid_r;
    out_rc_nxt    = out_rc_r;
    out_start_nxt = out_start_r;
    wr            = '{en: 1'b0, addr: ptr_r, data: TAG_FREE};
    run_cmd       = '{clr: 1'b0, step: 1'b0};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          run_cmd.clr = 1'b1;
          start_nxt   = '0;
          count_nxt   = cnt_ext[LEN_W-1:0];
          if (in_req_type == REQ_ALLOC) begin
            ptr_nxt = '0;
            if (cnt_ext == '0 || cnt_ext > CMP_W'(NUM_BLOCKS)) begin
              rc_nxt    = RC_NOSPACE;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            ptr_nxt = in_block_index[IDX_W-1:0];
            if (bidx_ext >= CMP_W'(NUM_BLOCKS)) begin
              rc_nxt    = RC_BADFREE;
              state_nxt = S_DONE;
            end else begin
              rc_nxt    = RC_OK;
              state_nxt = S_FREE_HEAD;
            end
          end
        end
      end

      // look for the first long enough free run
      S_SCAN: begin
        if (rd_tag == TAG_FREE) begin
          if (run_sts.len_zero) begin
            start_nxt = ptr_r;
          end
          if (run_sts.hit) begin
            run_cmd.clr = 1'b1;
            ptr_nxt     = run_sts.len_zero ? ptr_r : start_r;
            start_nxt   = run_sts.len_zero ? ptr_r : start_r;
            state_nxt   = S_WRITE;
          end else begin
            run_cmd.step = 1'b1;
            if (ptr_r == LAST_IDX) begin
              rc_nxt    = RC_NOSPACE;
              start_nxt = '0;
              state_nxt = S_DONE;
            end else begin
              ptr_nxt = ptr_r + IDX_W'(1);
            end
          end
        end else begin
          run_cmd.clr = 1'b1;
          if (ptr_r == LAST_IDX) begin
            rc_nxt    = RC_NOSPACE;
            start_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            ptr_nxt = ptr_r + IDX_W'(1);
          end
        end
      end

      // tag the run one block a cycle
      S_WRITE: begin
        wr.en = 1'b1;
        if (count_r == LEN_W'(1)) begin
          wr.data = TAG_SINGLE;
        end else if (run_sts.len_zero) begin
          wr.data = TAG_FIRST;
        end else if (run_sts.hit) begin
          wr.data = TAG_LAST;
        end else begin
          wr.data = TAG_MIDDLE;
        end
        if (run_sts.hit) begin
          rc_nxt    = RC_OK;
          state_nxt = S_DONE;
        end else begin
          run_cmd.step = 1'b1;
          ptr_nxt      = ptr_r + IDX_W'(1);
        end
      end

      // check the head of the run to free
      S_FREE_HEAD: begin
        if (rd_tag == TAG_SINGLE) begin
          wr.en     = 1'b1;
          state_nxt = S_DONE;
        end else if (rd_tag == TAG_FIRST) begin
          wr.en = 1'b1;
          if (ptr_r == LAST_IDX) begin
            state_nxt = S_DONE;
          end else begin
            ptr_nxt   = ptr_r + IDX_W'(1);
            state_nxt = S_FREE_WALK;
          end
        end else begin
          rc_nxt    = RC_BADFREE;
          state_nxt = S_DONE;
        end
      end

      // clear middle blocks up to and including the last one; any other tag or the heap end stops the walk
      S_FREE_WALK: begin
        if (rd_tag == TAG_MIDDLE) begin
          wr.en = 1'b1;
          if (ptr_r == LAST_IDX) begin
            state_nxt = S_DONE;
          end else begin
            ptr_nxt = ptr_r + IDX_W'(1);
          end
        end else if (rd_tag == TAG_LAST) begin
          wr.en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rc_nxt    = rc_r;
          out_start_nxt = (rc_r == RC_OK) ? START_W'(start_r) : '0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r       <= ptr_nxt;
    start_r     <= start_nxt;
    count_r     <= count_nxt;
    rc_r        <= rc_nxt;
    out_rc_r    <= out_rc_nxt;
    out_start_r <= out_start_nxt;
  end

endmodule

>>> hdl/cba_tag_store.sv
// tag store: one tag per heap block, one read and one write port
// depends on cba_pkg
module cba_tag_store
  import cba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tag_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output tag_t             rd_data
);

  tag_t tags_r [NUM_BLOCKS];

  // all blocks free after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        tags_r[i] <= TAG_FREE;
      end
    end else if (wr.en) begin
      tags_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = tags_r[rd_addr];

endmodule

>>> hdl/cba_run_unit.sv
// shared run counter: counts free blocks while scanning, written blocks while tagging
// depends on cba_pkg
module cba_run_unit
  import cba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  run_cmd_t         cmd,
  input  logic [LEN_W-1:0] count,
  output run_sts_t         sts
);

  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_p1;

  // one increment and one compare against the requested count
  assign len_p1       = len_r + LEN_W'(1);
  assign sts.hit      = (len_p1 >= count);
  assign sts.len_zero = (len_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cmd.clr) begin
      len_r <= '0;
    end else if (cmd.step) begin
      len_r <= len_p1;
    end
  end

endmodule

>>> dv/heap_sb_pkg.sv
`timescale 1ns / 1ps
// scoreboard for the contiguous block allocator: tracks the heap tags per accepted beat
// depends on cba_pkg for the tag type, widths and result codes
package heap_sb_pkg;
  import cba_pkg::*;

  localparam logic [REQ_W-1:0] REQ_FREE = 1'b1;

  class heap_scoreboard;
    tag_t               heap_tags[NUM_BLOCKS];
    logic [RC_W-1:0]    due_codes[$];
    logic [START_W-1:0] due_starts[$];
    int unsigned        fails;

    function new();
      foreach (heap_tags[i]) heap_tags[i] = TAG_FREE;
      fails = 0;
    endfunction

    // first-fit search; tags the run and returns the code and start block
    function void first_fit(input logic [CNT_IN_W-1:0] cnt,
                            output logic [RC_W-1:0] code,
                            output logic [START_W-1:0] start);
      int run_len;
      int run_start;
      bit found;
      run_len = 0;
      run_start = 0;
      found = 0;
      code = RC_NOSPACE;
      start = '0;
      if (cnt == 0 || int'(cnt) > NUM_BLOCKS) return;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        if (heap_tags[i] == TAG_FREE) begin
          if (run_len == 0) run_start = i;
          run_len++;
          if (run_len >= int'(cnt)) begin
            found = 1;
            break;
          end
        end else begin
          run_len = 0;
        end
      end
      if (!found) return;
      // a lone block is single, a longer run is first, middle..., last
      if (cnt == 1) begin
        heap_tags[run_start] = TAG_SINGLE;
      end else begin
        for (int k = 0; k < int'(cnt); k++) begin
          if (k == 0) heap_tags[run_start + k] = TAG_FIRST;
          else if (k == int'(cnt) - 1) heap_tags[run_start + k] = TAG_LAST;
          else heap_tags[run_start + k] = TAG_MIDDLE;
        end
      end
      code = RC_OK;
      start = run_start[START_W-1:0];
    endfunction

    // clear a single block, or a run from its first block through its last tag
    function logic [RC_W-1:0] release_run(input logic [BIDX_W-1:0] idx);
      int pos;
      pos = int'(idx);
      if (pos >= NUM_BLOCKS) return RC_BADFREE;
      if (heap_tags[pos] == TAG_SINGLE) begin
        heap_tags[pos] = TAG_FREE;
        return RC_OK;
      end
      if (heap_tags[pos] != TAG_FIRST) return RC_BADFREE;
      heap_tags[pos] = TAG_FREE;
      // walk stops after the last tag, at any foreign tag, or at the heap end
      for (int j = pos + 1; j < NUM_BLOCKS; j++) begin
        if (heap_tags[j] == TAG_MIDDLE) begin
          heap_tags[j] = TAG_FREE;
        end else if (heap_tags[j] == TAG_LAST) begin
          heap_tags[j] = TAG_FREE;
          break;
        end else begin
          break;
        end
      end
      return RC_OK;
    endfunction

    // accepted request beat: update the heap and queue the expected grant
    function void apply_request(logic [REQ_W-1:0] req, logic [CNT_IN_W-1:0] cnt,
                                logic [BIDX_W-1:0] idx);
      logic [RC_W-1:0]    code;
      logic [START_W-1:0] start;
      start = '0;
      if (req == REQ_ALLOC) first_fit(cnt, code, start);
      else code = release_run(idx);
      due_codes.push_back(code);
      due_starts.push_back(start);
    endfunction

    function void flag(string msg);
      fails++;
      if (fails <= 10) $display("mismatch: %s", msg);
    endfunction

    // accepted result beat: compare against the oldest outstanding grant
    function void check_grant(logic [RC_W-1:0] code, logic [START_W-1:0] start);
      logic [RC_W-1:0]    want_code;
      logic [START_W-1:0] want_start;
      if (due_codes.size() == 0) begin
        flag($sformatf("result with nothing outstanding: code %0d start %0d", code, start));
        return;
      end
      want_code = due_codes.pop_front();
      want_start = due_starts.pop_front();
      if (code !== want_code)
        flag($sformatf("result_code expected %0d got %0d", want_code, code));
      if (start !== want_start)
        flag($sformatf("start_index expected %0d got %0d", want_start, start));
    endfunction

    function int pending();
      return due_codes.size();
    endfunction

    // random head of a live run, or -1 when the heap is empty
    function int live_head();
      int heads[$];
      foreach (heap_tags[i])
        if (heap_tags[i] == TAG_SINGLE || heap_tags[i] == TAG_FIRST) heads.push_back(i);
      if (heads.size() == 0) return -1;
      return heads[$urandom_range(0, heads.size() - 1)];
    endfunction
  endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// testbench top for contiguous_block_allocator_top: bursty request driver,
// patterned result stalls, checks every grant via heap_sb_pkg (needs cba_pkg)
module tb_top;
  import cba_pkg::*;
  import heap_sb_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 40;
  localparam int RX_OPEN   = 0;
  localparam int RX_LIGHT  = 1;
  localparam int RX_HEAVY  = 2;
  localparam int RX_SQUARE = 3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [CNT_IN_W-1:0] in_alloc_count = '0;
  logic [BIDX_W-1:0]   in_block_index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [RC_W-1:0]     out_result_code;
  logic [START_W-1:0]  out_start_index;

  heap_scoreboard sb = new();

  int          rx_mode = RX_OPEN;
  logic [7:0]  rx_cycle = '0;

  contiguous_block_allocator_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_alloc_count  (in_alloc_count),
    .in_block_index  (in_block_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_code (out_result_code),
    .out_start_index (out_start_index)
  );

  // clock
  always #5 clk = ~clk;

  // result side stall pattern, mode picked anew each time the 8-bit rx_cycle counter wraps
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 8'd1;
    if (rx_cycle == 8'd0) rx_mode <= $urandom_range(RX_OPEN, RX_SQUARE);
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
      default:  out_ready <= rx_cycle[4];
    endcase
  end

  // result beat check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_grant(out_result_code, out_start_index);
  end

  // hold one request beat until accepted, then record it
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [CNT_IN_W-1:0] cnt,
                          input logic [BIDX_W-1:0] idx);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_alloc_count <= cnt;
    in_block_index <= idx;
    do @(posedge clk); while (!in_ready);
    sb.apply_request(req, cnt, idx);
  endtask

  task automatic alloc_of(input int cnt);
    send_req(REQ_ALLOC, cnt[CNT_IN_W-1:0], BIDX_W'($urandom_range(0, 15)));
  endtask

  task automatic free_at(input int idx);
    send_req(REQ_FREE, CNT_IN_W'($urandom_range(0, 31)), idx[BIDX_W-1:0]);
  endtask

  // idle gap with in_valid low, its length given by n; a zero gap keeps the beats back to back
  task automatic idle(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off requests until every grant has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int burst_left;
    int roll;
    int head;
    int c;
    int cnt;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bad sizes, bad frees, full heap, hole reuse
    alloc_of(0);
    alloc_of(31);
    alloc_of(17);
    free_at(7);
    alloc_of(16);
    alloc_of(1);
    free_at(5);
    free_at(15);
    free_at(0);
    alloc_of(1);
    alloc_of(3);
    alloc_of(2);
    alloc_of(1);
    free_at(1);
    alloc_of(2);
    alloc_of(4);
    alloc_of(1);
    free_at(6);
    alloc_of(5);
    alloc_of(1);
    alloc_of(1);
    free_at(11);
    free_at(0);
    free_at(4);
    free_at(3);
    drain();

    // random: mostly allocs and frees of live runs, some noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain();
      if (burst_left == 0) begin
        idle($urandom_range(0, 12));
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      roll = $urandom_range(0, 99);
      head = sb.live_head();
      if (roll < 45 || (roll < 90 && head < 0)) begin
        c = $urandom_range(0, 99);
        if (c < 60) cnt = $urandom_range(1, 3);
        else if (c < 88) cnt = $urandom_range(4, 8);
        else if (c < 95) cnt = $urandom_range(9, 16);
        else if (c < 97) cnt = 0;
        else cnt = $urandom_range(17, 31);
        alloc_of(cnt);
      end else if (roll < 90) begin
        free_at(head);
      end else begin
        free_at($urandom_range(0, 15));
      end
    end

    // wait for the last grants, then stay idle before the final verdict
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
hdl/cba_pkg.sv
hdl/cba_tag_store.sv
hdl/cba_run_unit.sv
hdl/contiguous_block_allocator_top.sv
dv/heap_sb_pkg.sv
dv/tb_top.sv
